// ===== design/clen_pkg.sv =====
package clen_pkg;

    // ALU operation codes
    typedef logic [1:0] alu_op_t;
    localparam alu_op_t OP_ADD = 2'd0;
    localparam alu_op_t OP_SUB = 2'd1;
    localparam alu_op_t OP_MUL = 2'd2;

    // Operand codes: named state and input words, then scratch temporaries
    typedef logic [4:0] opd_t;
    typedef logic [3:0] tidx_t;

    localparam int NUM_TEMPS = 9;

    localparam tidx_t TI_0 = 4'd0;
    localparam tidx_t TI_1 = 4'd1;
    localparam tidx_t TI_2 = 4'd2;
    localparam tidx_t TI_3 = 4'd3;
    localparam tidx_t TI_4 = 4'd4;
    localparam tidx_t TI_5 = 4'd5;
    localparam tidx_t TI_6 = 4'd6;
    localparam tidx_t TI_7 = 4'd7;
    localparam tidx_t TI_8 = 4'd8;

    localparam opd_t OPD_A_RE   = 5'd0;
    localparam opd_t OPD_A_IM   = 5'd1;
    localparam opd_t OPD_B_RE   = 5'd2;
    localparam opd_t OPD_B_IM   = 5'd3;
    localparam opd_t OPD_C_RE   = 5'd4;
    localparam opd_t OPD_C_IM   = 5'd5;
    localparam opd_t OPD_UN_RE  = 5'd6;
    localparam opd_t OPD_UN_IM  = 5'd7;
    localparam opd_t OPD_UN2_RE = 5'd8;
    localparam opd_t OPD_UN2_IM = 5'd9;
    localparam opd_t OPD_AN_RE  = 5'd10;
    localparam opd_t OPD_AN_IM  = 5'd11;
    localparam opd_t OPD_BN_RE  = 5'd12;
    localparam opd_t OPD_BN_IM  = 5'd13;
    localparam opd_t OPD_BN2_RE = 5'd14;
    localparam opd_t OPD_BN2_IM = 5'd15;
    localparam opd_t OPD_T0 = {1'b1, TI_0};
    localparam opd_t OPD_T1 = {1'b1, TI_1};
    localparam opd_t OPD_T2 = {1'b1, TI_2};
    localparam opd_t OPD_T3 = {1'b1, TI_3};
    localparam opd_t OPD_T4 = {1'b1, TI_4};
    localparam opd_t OPD_T5 = {1'b1, TI_5};
    localparam opd_t OPD_T6 = {1'b1, TI_6};
    localparam opd_t OPD_T7 = {1'b1, TI_7};
    localparam opd_t OPD_T8 = {1'b1, TI_8};

    typedef struct packed {
        alu_op_t op;
        opd_t    src_a;
        opd_t    src_b;
        tidx_t   dst;
        logic    last;
    } uop_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctrl_t;

    typedef struct packed {
        logic done;
        logic sat;
    } alu_stat_t;

    localparam int PC_W = 6;
    localparam logic [PC_W-1:0] PROG_TERM  = 6'd0;
    localparam logic [PC_W-1:0] PROG_FINAL = 6'd16;

    function automatic uop_t mk(input alu_op_t op, input opd_t a, input opd_t b,
                                input tidx_t d, input logic last);
        uop_t u;
        u.op    = op;
        u.src_a = a;
        u.src_b = b;
        u.dst   = d;
        u.last  = last;
        return u;
    endfunction

    // Microprogram: inner term u = c + a_next*u_next + b_next2*u_next2,
    // final term S = P0*u0 + P1*u_next. Results end in T0/T1.
    function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            6'd0:  u = mk(OP_MUL, OPD_AN_RE,  OPD_UN_RE,  TI_0, 1'b0);
            6'd1:  u = mk(OP_MUL, OPD_AN_IM,  OPD_UN_IM,  TI_1, 1'b0);
            6'd2:  u = mk(OP_SUB, OPD_T0,     OPD_T1,     TI_0, 1'b0);
            6'd3:  u = mk(OP_MUL, OPD_AN_RE,  OPD_UN_IM,  TI_1, 1'b0);
            6'd4:  u = mk(OP_MUL, OPD_AN_IM,  OPD_UN_RE,  TI_2, 1'b0);
            6'd5:  u = mk(OP_ADD, OPD_T1,     OPD_T2,     TI_1, 1'b0);
            6'd6:  u = mk(OP_ADD, OPD_C_RE,   OPD_T0,     TI_0, 1'b0);
            6'd7:  u = mk(OP_ADD, OPD_C_IM,   OPD_T1,     TI_1, 1'b0);
            6'd8:  u = mk(OP_MUL, OPD_BN2_RE, OPD_UN2_RE, TI_2, 1'b0);
            6'd9:  u = mk(OP_MUL, OPD_BN2_IM, OPD_UN2_IM, TI_3, 1'b0);
            6'd10: u = mk(OP_SUB, OPD_T2,     OPD_T3,     TI_2, 1'b0);
            6'd11: u = mk(OP_MUL, OPD_BN2_RE, OPD_UN2_IM, TI_3, 1'b0);
            6'd12: u = mk(OP_MUL, OPD_BN2_IM, OPD_UN2_RE, TI_4, 1'b0);
            6'd13: u = mk(OP_ADD, OPD_T3,     OPD_T4,     TI_3, 1'b0);
            6'd14: u = mk(OP_ADD, OPD_T0,     OPD_T2,     TI_0, 1'b0);
            6'd15: u = mk(OP_ADD, OPD_T1,     OPD_T3,     TI_1, 1'b1);
            6'd16: u = mk(OP_ADD, OPD_A_RE,   OPD_B_RE,   TI_0, 1'b0);
            6'd17: u = mk(OP_ADD, OPD_A_IM,   OPD_B_IM,   TI_1, 1'b0);
            6'd18: u = mk(OP_MUL, OPD_AN_RE,  OPD_T0,     TI_2, 1'b0);
            6'd19: u = mk(OP_MUL, OPD_AN_IM,  OPD_T1,     TI_3, 1'b0);
            6'd20: u = mk(OP_SUB, OPD_T2,     OPD_T3,     TI_2, 1'b0);
            6'd21: u = mk(OP_MUL, OPD_AN_RE,  OPD_T1,     TI_3, 1'b0);
            6'd22: u = mk(OP_MUL, OPD_AN_IM,  OPD_T0,     TI_4, 1'b0);
            6'd23: u = mk(OP_ADD, OPD_T3,     OPD_T4,     TI_3, 1'b0);
            6'd24: u = mk(OP_ADD, OPD_T2,     OPD_BN_RE,  TI_2, 1'b0);
            6'd25: u = mk(OP_ADD, OPD_T3,     OPD_BN_IM,  TI_3, 1'b0);
            6'd26: u = mk(OP_MUL, OPD_BN2_RE, OPD_UN2_RE, TI_4, 1'b0);
            6'd27: u = mk(OP_MUL, OPD_BN2_IM, OPD_UN2_IM, TI_5, 1'b0);
            6'd28: u = mk(OP_SUB, OPD_T4,     OPD_T5,     TI_4, 1'b0);
            6'd29: u = mk(OP_MUL, OPD_BN2_RE, OPD_UN2_IM, TI_5, 1'b0);
            6'd30: u = mk(OP_MUL, OPD_BN2_IM, OPD_UN2_RE, TI_6, 1'b0);
            6'd31: u = mk(OP_ADD, OPD_T5,     OPD_T6,     TI_5, 1'b0);
            6'd32: u = mk(OP_ADD, OPD_C_RE,   OPD_T4,     TI_4, 1'b0);
            6'd33: u = mk(OP_ADD, OPD_C_IM,   OPD_T5,     TI_5, 1'b0);
            6'd34: u = mk(OP_MUL, OPD_T0,     OPD_T4,     TI_6, 1'b0);
            6'd35: u = mk(OP_MUL, OPD_T1,     OPD_T5,     TI_7, 1'b0);
            6'd36: u = mk(OP_SUB, OPD_T6,     OPD_T7,     TI_6, 1'b0);
            6'd37: u = mk(OP_MUL, OPD_T0,     OPD_T5,     TI_7, 1'b0);
            6'd38: u = mk(OP_MUL, OPD_T1,     OPD_T4,     TI_8, 1'b0);
            6'd39: u = mk(OP_ADD, OPD_T7,     OPD_T8,     TI_7, 1'b0);
            6'd40: u = mk(OP_MUL, OPD_T2,     OPD_UN_RE,  TI_0, 1'b0);
            6'd41: u = mk(OP_MUL, OPD_T3,     OPD_UN_IM,  TI_1, 1'b0);
            6'd42: u = mk(OP_SUB, OPD_T0,     OPD_T1,     TI_0, 1'b0);
            6'd43: u = mk(OP_MUL, OPD_T2,     OPD_UN_IM,  TI_1, 1'b0);
            6'd44: u = mk(OP_MUL, OPD_T3,     OPD_UN_RE,  TI_8, 1'b0);
            6'd45: u = mk(OP_ADD, OPD_T1,     OPD_T8,     TI_1, 1'b0);
            6'd46: u = mk(OP_ADD, OPD_T6,     OPD_T0,     TI_0, 1'b0);
            6'd47: u = mk(OP_ADD, OPD_T7,     OPD_T1,     TI_1, 1'b1);
            default: u = mk(OP_ADD, OPD_T0,   OPD_T1,     TI_0, 1'b1);
        endcase
        return u;
    endfunction

endpackage

// ===== design/clen_if.sv =====
interface clen_term_if #(parameter int DATA_WIDTH = 32) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;
    logic signed [DATA_WIDTH-1:0] c_re;
    logic signed [DATA_WIDTH-1:0] c_im;
    logic                         last_term;

    modport source (output valid, a_re, a_im, b_re, b_im, c_re, c_im, last_term,
                    input ready);
    modport sink   (input valid, a_re, a_im, b_re, b_im, c_re, c_im, last_term,
                    output ready);
endinterface

interface clen_sum_if #(parameter int DATA_WIDTH = 32) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] sum_re;
    logic signed [DATA_WIDTH-1:0] sum_im;
    logic                         overflow;

    modport source (output valid, sum_re, sum_im, overflow, input ready);
    modport sink   (input valid, sum_re, sum_im, overflow, output ready);
endinterface

// ===== design/clenshaw_recurrence_sum_top.sv =====
// Clenshaw backward summation of a complex three-term recurrence, Q-format fixed point.
// Inner term: 8 multiplies and 8 adds or subtracts; ready stays low until the term is through.
// Final term: 16 multiplies and 16 adds or subtracts; the sum is then held in the output slot.
// Terms are processed one at a time on the one shared ALU, whose multiply takes four half-width passes.
// Reset (rst_n low, asynchronous) clears the recurrence state, the saturation flag,
// the sequencer and the output slot; scratch temporaries need no reset.
module clenshaw_recurrence_sum_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input logic        clk,
    input logic        rst_n,
    clen_term_if.sink  terms,
    clen_sum_if.source sums
);
    import clen_pkg::*;

    localparam int W = DATA_WIDTH;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;  // wait for a term
    localparam logic [2:0] S_ISSUE = 3'd1;  // present temp read addresses
    localparam logic [2:0] S_FETCH = 3'd2;  // operands ready, start the ALU
    localparam logic [2:0] S_WAIT  = 3'd3;  // wait for the ALU, write back
    localparam logic [2:0] S_READ  = 3'd4;  // read the results from T0/T1
    localparam logic [2:0] S_DONE  = 3'd5;  // commit state or emit the sum

    logic [2:0]      state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    uop_t            uop;

    // Latched term
    logic signed [W-1:0] a_re_reg, a_im_reg, b_re_reg, b_im_reg, c_re_reg, c_im_reg;
    logic                last_reg;

    // Recurrence state
    logic signed [W-1:0] un_re_reg, un_im_reg, un2_re_reg, un2_im_reg;
    logic signed [W-1:0] an_re_reg, an_im_reg, bn_re_reg, bn_im_reg;
    logic signed [W-1:0] bn2_re_reg, bn2_im_reg;
    logic                sat_seen_reg;

    // Output slot
    logic                out_valid_reg;
    logic signed [W-1:0] sum_re_reg, sum_im_reg;
    logic                ovf_reg;

    // Scratch temporaries and ALU hookup
    logic                ram_we;
    tidx_t               raddr_a, raddr_b;
    logic [W-1:0]        rdata_a, rdata_b;
    alu_ctrl_t           alu_ctrl;
    alu_stat_t           alu_stat;
    logic signed [W-1:0] alu_x, alu_y, alu_res;

    logic accept;
    logic load_out;
    logic commit;

    assign uop    = uop_rom(pc_reg);
    assign accept = terms.valid && terms.ready;

    assign terms.ready = (state_reg == S_IDLE);

    // Operand select: a named word by code, otherwise the temp read on this port
    function automatic logic signed [W-1:0] pick(input opd_t code, input logic [W-1:0] tmp);
        logic signed [W-1:0] v;
        case (code)
            OPD_A_RE:   v = a_re_reg;
            OPD_A_IM:   v = a_im_reg;
            OPD_B_RE:   v = b_re_reg;
            OPD_B_IM:   v = b_im_reg;
            OPD_C_RE:   v = c_re_reg;
            OPD_C_IM:   v = c_im_reg;
            OPD_UN_RE:  v = un_re_reg;
            OPD_UN_IM:  v = un_im_reg;
            OPD_UN2_RE: v = un2_re_reg;
            OPD_UN2_IM: v = un2_im_reg;
            OPD_AN_RE:  v = an_re_reg;
            OPD_AN_IM:  v = an_im_reg;
            OPD_BN_RE:  v = bn_re_reg;
            OPD_BN_IM:  v = bn_im_reg;
            OPD_BN2_RE: v = bn2_re_reg;
            OPD_BN2_IM: v = bn2_im_reg;
            default:    v = $signed(tmp);
        endcase
        return v;
    endfunction

    assign alu_x = pick(uop.src_a, rdata_a);
    assign alu_y = pick(uop.src_b, rdata_b);

    assign alu_ctrl.start = (state_reg == S_FETCH);
    assign alu_ctrl.op    = uop.op;

    // Outside of issue, keep the read ports on T0/T1 so the results stay put
    assign raddr_a = (state_reg == S_ISSUE) ? uop.src_a[3:0] : TI_0;
    assign raddr_b = (state_reg == S_ISSUE) ? uop.src_b[3:0] : TI_1;

    assign ram_we = (state_reg == S_WAIT) && alu_stat.done;

    // Final term waits for a free output slot; an inner term commits at once
    assign load_out = (state_reg == S_DONE) && last_reg && (!out_valid_reg || sums.ready);
    assign commit   = (state_reg == S_DONE) && !last_reg;

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pc_next    = terms.last_term ? PROG_FINAL : PROG_TERM;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (alu_stat.done)
                begin
                    if (uop.last)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        pc_next    = pc_reg + PC_W'(1);
                        state_next = S_ISSUE;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (commit || load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= PROG_TERM;
            out_valid_reg <= 1'b0;
            sat_seen_reg  <= 1'b0;
            un_re_reg     <= '0;
            un_im_reg     <= '0;
            un2_re_reg    <= '0;
            un2_im_reg    <= '0;
            an_re_reg     <= '0;
            an_im_reg     <= '0;
            bn_re_reg     <= '0;
            bn_im_reg     <= '0;
            bn2_re_reg    <= '0;
            bn2_im_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;

            // Drop the held sum once taken; a new one may replace it in the same cycle
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (sums.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (ram_we && alu_stat.sat)
            begin
                sat_seen_reg <= 1'b1;
            end

            if (commit)
            begin
                // Advance the recurrence by one index
                un2_re_reg <= un_re_reg;
                un2_im_reg <= un_im_reg;
                un_re_reg  <= $signed(rdata_a);
                un_im_reg  <= $signed(rdata_b);
                bn2_re_reg <= bn_re_reg;
                bn2_im_reg <= bn_im_reg;
                bn_re_reg  <= b_re_reg;
                bn_im_reg  <= b_im_reg;
                an_re_reg  <= a_re_reg;
                an_im_reg  <= a_im_reg;
            end
            else if (load_out)
            begin
                // Sum emitted: clear the recurrence state and the saturation flag for the next one
                sat_seen_reg <= 1'b0;
                un_re_reg    <= '0;
                un_im_reg    <= '0;
                un2_re_reg   <= '0;
                un2_im_reg   <= '0;
                an_re_reg    <= '0;
                an_im_reg    <= '0;
                bn_re_reg    <= '0;
                bn_im_reg    <= '0;
                bn2_re_reg   <= '0;
                bn2_im_reg   <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_re_reg <= terms.a_re;
            a_im_reg <= terms.a_im;
            b_re_reg <= terms.b_re;
            b_im_reg <= terms.b_im;
            c_re_reg <= terms.c_re;
            c_im_reg <= terms.c_im;
            last_reg <= terms.last_term;
        end
        if (load_out)
        begin
            sum_re_reg <= $signed(rdata_a);
            sum_im_reg <= $signed(rdata_b);
            ovf_reg    <= sat_seen_reg;
        end
    end

    assign sums.valid    = out_valid_reg;
    assign sums.sum_re   = sum_re_reg;
    assign sums.sum_im   = sum_im_reg;
    assign sums.overflow = ovf_reg;

    clen_ram #(
        .WIDTH (W),
        .DEPTH (NUM_TEMPS)
    ) u_temps (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (uop.dst),
        .wdata   (alu_res),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    clen_alu #(
        .DATA_WIDTH (W),
        .FRAC_BITS  (FRAC_BITS)
    ) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (alu_ctrl),
        .x     (alu_x),
        .y     (alu_y),
        .stat  (alu_stat),
        .res   (alu_res)
    );

endmodule

// ===== design/clen_ram.sv =====
module clen_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                           rdata_a,
    output logic [WIDTH-1:0]                           rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== design/clen_alu.sv =====
module clen_alu #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  clen_pkg::alu_ctrl_t          ctrl,
    input  logic signed [DATA_WIDTH-1:0] x,
    input  logic signed [DATA_WIDTH-1:0] y,
    output clen_pkg::alu_stat_t          stat,
    output logic signed [DATA_WIDTH-1:0] res
);
    import clen_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int H  = (DATA_WIDTH + 1) / 2;
    localparam int MW = 2 * H;
    localparam int AW = 4 * H;
    localparam int PW = AW + 1;

    localparam logic [1:0] AS_IDLE = 2'd0;
    localparam logic [1:0] AS_MUL  = 2'd1;
    localparam logic [1:0] AS_NEG  = 2'd2;
    localparam logic [1:0] AS_SAT  = 2'd3;

    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    logic [1:0]           state_reg, state_next;
    logic [1:0]           pcnt_reg, pcnt_next;
    logic                 done_reg, done_next;
    logic                 sat_reg, sat_next;
    logic signed [W-1:0]  res_reg, res_next;
    logic [MW-1:0]        ma_reg, ma_next;
    logic [MW-1:0]        mb_reg, mb_next;
    logic                 neg_reg, neg_next;
    logic [AW-1:0]        acc_reg, acc_next;
    logic signed [PW-1:0] val_reg, val_next;

    logic [H-1:0]         a_half, b_half;
    logic [MW-1:0]        pp;
    logic [AW-1:0]        pp_ext;
    logic signed [W:0]    sum;
    logic signed [PW-1:0] shifted;
    logic                 fits;

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
        return v[W-1] ? W'(~v + 1'b1) : W'(v);
    endfunction

    // one half-width partial product per cycle
    assign a_half = pcnt_reg[1] ? ma_reg[MW-1:H] : ma_reg[H-1:0];
    assign b_half = pcnt_reg[0] ? mb_reg[MW-1:H] : mb_reg[H-1:0];
    assign pp     = a_half * b_half;

    always_comb
    begin
        case (pcnt_reg)
            2'd0:    pp_ext = AW'(pp);
            2'd3:    pp_ext = AW'(pp) << (2 * H);
            default: pp_ext = AW'(pp) << H;
        endcase
    end

    assign sum = (ctrl.op == OP_SUB) ? ({x[W-1], x} - {y[W-1], y})
                                     : ({x[W-1], x} + {y[W-1], y});

    assign shifted = val_reg >>> FRAC_BITS;
    assign fits    = (&shifted[PW-1:W-1]) | ~(|shifted[PW-1:W-1]);

    always_comb
    begin
        state_next = state_reg;
        pcnt_next  = pcnt_reg;
        done_next  = 1'b0;
        sat_next   = sat_reg;
        res_next   = res_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        val_next   = val_reg;
        case (state_reg)
            AS_IDLE:
            begin
                if (ctrl.start)
                begin
                    if (ctrl.op == OP_MUL)
                    begin
                        ma_next    = MW'(mag(x));
                        mb_next    = MW'(mag(y));
                        neg_next   = x[W-1] ^ y[W-1];
                        acc_next   = '0;
                        pcnt_next  = 2'd0;
                        state_next = AS_MUL;
                    end
                    else
                    begin
                        done_next = 1'b1;
                        if (sum[W] != sum[W-1])
                        begin
                            sat_next = 1'b1;
                            res_next = sum[W] ? VMIN : VMAX;
                        end
                        else
                        begin
                            sat_next = 1'b0;
                            res_next = sum[W-1:0];
                        end
                    end
                end
            end
            AS_MUL:
            begin
                acc_next  = acc_reg + pp_ext;
                pcnt_next = pcnt_reg + 2'd1;
                if (pcnt_reg == 2'd3)
                begin
                    state_next = AS_NEG;
                end
            end
            AS_NEG:
            begin
                val_next   = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
                state_next = AS_SAT;
            end
            AS_SAT:
            begin
                done_next  = 1'b1;
                sat_next   = ~fits;
                res_next   = fits ? shifted[W-1:0] : (shifted[PW-1] ? VMIN : VMAX);
                state_next = AS_IDLE;
            end
            default:
            begin
                state_next = AS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AS_IDLE;
            pcnt_reg  <= 2'd0;
            done_reg  <= 1'b0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pcnt_reg  <= pcnt_next;
            done_reg  <= done_next;
            sat_reg   <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        val_reg <= val_next;
    end

    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;
    assign res       = res_reg;

endmodule

// ===== tb/sv/clen_sum_sb_pkg.sv =====
package clen_sum_sb_pkg;

    localparam int DW = 32;
    localparam int FB = 16;

    localparam longint V_MAX = (64'sd1 <<< (DW - 1)) - 1;
    localparam longint V_MIN = -(64'sd1 <<< (DW - 1));

    typedef logic signed [DW-1:0] word_t;

    typedef struct packed {
        word_t a_re;
        word_t a_im;
        word_t b_re;
        word_t b_im;
        word_t c_re;
        word_t c_im;
        logic  last_term;
    } term_t;

    typedef struct packed {
        word_t sum_re;
        word_t sum_im;
        logic  overflow;
    } sum_t;

    typedef struct packed {
        logic signed [63:0] re;
        logic signed [63:0] im;
    } cplx_t;

    class clen_sum_scoreboard;
        // recurrence state carried from one term to the next
        cplx_t un, un2, an, bn, bn2;
        bit    sat_seen;

        sum_t  sums_due[$];
        int    errors;
        int    sums_checked;
        int    sat_sums;

        function new();
            clear_state();
            errors       = 0;
            sums_checked = 0;
            sat_sums     = 0;
        endfunction

        function void clear_state();
            un       = '0;
            un2      = '0;
            an       = '0;
            bn       = '0;
            bn2      = '0;
            sat_seen = 1'b0;
        endfunction

        function longint clamp(longint x);
            if (x > V_MAX)
            begin
                sat_seen = 1'b1;
                return V_MAX;
            end
            if (x < V_MIN)
            begin
                sat_seen = 1'b1;
                return V_MIN;
            end
            return x;
        endfunction

        // truncate toward minus infinity, then saturate
        function longint mul_q(longint x, longint y);
            longint p;
            p = x * y;
            return clamp(p >>> FB);
        endfunction

        function cplx_t cmul(cplx_t x, cplx_t y);
            longint rr, ii, ri, ir;
            cplx_t  r;
            rr   = mul_q(x.re, y.re);
            ii   = mul_q(x.im, y.im);
            ri   = mul_q(x.re, y.im);
            ir   = mul_q(x.im, y.re);
            r.re = clamp(rr - ii);
            r.im = clamp(ri + ir);
            return r;
        endfunction

        function cplx_t cadd(cplx_t x, cplx_t y);
            cplx_t r;
            r.re = clamp(x.re + y.re);
            r.im = clamp(x.im + y.im);
            return r;
        endfunction

        // Fold one accepted term into the state; a final term yields the sum.
        function void note_term(term_t t);
            cplx_t a, b, c, u, p0, p1, u0, s;
            sum_t  e;
            a.re = $signed(t.a_re);
            a.im = $signed(t.a_im);
            b.re = $signed(t.b_re);
            b.im = $signed(t.b_im);
            c.re = $signed(t.c_re);
            c.im = $signed(t.c_im);
            if (!t.last_term)
            begin
                u   = cadd(cadd(c, cmul(an, un)), cmul(bn2, un2));
                un2 = un;
                un  = u;
                bn2 = bn;
                bn  = b;
                an  = a;
            end
            else
            begin
                p0 = cadd(a, b);
                p1 = cadd(cmul(an, p0), bn);
                u0 = cadd(c, cmul(bn2, un2));
                s  = cadd(cmul(p0, u0), cmul(p1, un));
                e.sum_re   = s.re[DW-1:0];
                e.sum_im   = s.im[DW-1:0];
                e.overflow = sat_seen;
                sums_due.push_back(e);
                clear_state();
            end
        endfunction

        function void compare_field(string field, logic [DW-1:0] want,
                                    logic [DW-1:0] seen, longint stamp);
            if (seen !== want)
            begin
                errors++;
                $display("%0d ns: %s expected %0h got %0h", stamp, field, want, seen);
            end
        endfunction

        function void check_sum(sum_t got, longint stamp);
            sum_t e;
            if (sums_due.size() == 0)
            begin
                errors++;
                $display("%0d ns: unexpected sum, expected none got re %0h im %0h ovf %0b",
                         stamp, got.sum_re, got.sum_im, got.overflow);
                return;
            end
            e = sums_due.pop_front();
            sums_checked++;
            if (e.overflow)
                sat_sums++;
            compare_field("sum_re", e.sum_re, got.sum_re, stamp);
            compare_field("sum_im", e.sum_im, got.sum_im, stamp);
            compare_field("overflow", e.overflow, got.overflow, stamp);
        endfunction

        function int pending();
            return sums_due.size();
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_clenshaw_recurrence_sum_top.sv =====
module tb_clenshaw_recurrence_sum_top;
    timeunit 1ns;
    timeprecision 1ps;

    import clen_sum_sb_pkg::*;

    typedef enum int {VAL_FULL, VAL_SMALL, VAL_EDGE} val_kind_e;

    localparam word_t W_MAX  = 32'sh7FFF_FFFF;
    localparam word_t W_MIN  = 32'sh8000_0000;
    localparam word_t W_NEG1 = -32'sd1;
    localparam word_t Q_ONE  = 32'sh0001_0000;
    localparam word_t Q_HALF = 32'sh0000_8000;
    localparam word_t Q_TWO  = 32'sh0002_0000;

    localparam int RANDOM_TERMS = 1600;
    localparam int HOLD_CYCLES  = 3000;
    // give the drain a margin beyond the time that a final term takes
    localparam int DRAIN_CYCLES = 300;

    logic clk;
    logic rst_n;

    clen_term_if #(.DATA_WIDTH(DW)) terms_if ();
    clen_sum_if  #(.DATA_WIDTH(DW)) sums_if ();

    clenshaw_recurrence_sum_top #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FB)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .terms (terms_if),
        .sums  (sums_if)
    );

    clen_sum_scoreboard sb = new();

    bit   burst_tx;       // sender offers back to back while set
    bit   hold_off;       // receiver refuses every result while set
    int   stall_left;     // cycles the receiver still keeps ready low
    int   calm_left;      // results the receiver takes without stalling
    int   terms_sent;
    int   sums_held;
    sum_t rx_sum;

    // Free-running clock, 4 ns period.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Build one term from explicit field values.
    function automatic term_t mk_term(word_t ar, word_t ai, word_t br, word_t bi,
                                      word_t cr, word_t ci, logic last);
        term_t t;
        t.a_re      = ar;
        t.a_im      = ai;
        t.b_re      = br;
        t.b_im      = bi;
        t.c_re      = cr;
        t.c_im      = ci;
        t.last_term = last;
        return t;
    endfunction

    // Draw one Q15.16 word. Small values stay within +-2.0 so that most sums
    // of moderate length do not saturate; edge values hit the rails.
    function automatic word_t pick_word(val_kind_e kind);
        case (kind)
            VAL_SMALL: return word_t'($urandom_range(0, 32'h3_FFFF)) - 32'sh0002_0000;
            VAL_EDGE:
            begin
                case ($urandom_range(0, 5))
                    0:       return W_MAX;
                    1:       return W_MIN;
                    2:       return '0;
                    3:       return W_NEG1;
                    4:       return Q_ONE;
                    default: return -Q_ONE;
                endcase
            end
            default:   return word_t'($urandom);
        endcase
    endfunction

    // Draw one term. With mixed set every field picks its own kind; with
    // real_only set the imaginary parts are zero.
    function automatic term_t rand_term(val_kind_e kind, bit mixed, bit real_only,
                                        logic last);
        term_t     t;
        val_kind_e k [6];
        for (int i = 0; i < 6; i++)
            k[i] = mixed ? val_kind_e'($urandom_range(0, 2)) : kind;
        t = mk_term(pick_word(k[0]), pick_word(k[1]), pick_word(k[2]),
                    pick_word(k[3]), pick_word(k[4]), pick_word(k[5]), last);
        if (real_only)
        begin
            t.a_im = '0;
            t.b_im = '0;
            t.c_im = '0;
        end
        return t;
    endfunction

    // Offer one term after a random gap and hold it until the block takes it.
    // Drive at the falling edge, detect acceptance at the rising edge.
    task automatic push_term(input term_t t);
        int gap;
        gap = burst_tx ? 0 : $urandom_range(0, 10);
        repeat (gap)
        begin
            @(negedge clk);
            terms_if.valid <= 1'b0;
        end
        @(negedge clk);
        terms_if.a_re      <= t.a_re;
        terms_if.a_im      <= t.a_im;
        terms_if.b_re      <= t.b_re;
        terms_if.b_im      <= t.b_im;
        terms_if.c_re      <= t.c_re;
        terms_if.c_im      <= t.c_im;
        terms_if.last_term <= t.last_term;
        terms_if.valid     <= 1'b1;
        @(posedge clk);
        while (!terms_if.ready)
            @(posedge clk);
        sb.note_term(t);
        terms_sent++;
    endtask

    // Receiver: drop ready in reset and while a stall or the long hold-off is running,
    // otherwise raise it. Only one assignment per falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
            sums_if.ready <= 1'b0;
        else if (stall_left > 0 || hold_off)
        begin
            sums_if.ready <= 1'b0;
            if (stall_left > 0)
                stall_left--;
        end
        else
            sums_if.ready <= 1'b1;
    end

    // Sample results at the rising edge, check them, and draw the stall that
    // precedes the next one. Now and then run a calm stretch with no stalls.
    always @(posedge clk)
    begin
        if (rst_n && sums_if.valid && sums_if.ready)
        begin
            rx_sum.sum_re   = sums_if.sum_re;
            rx_sum.sum_im   = sums_if.sum_im;
            rx_sum.overflow = sums_if.overflow;
            sb.check_sum(rx_sum, $time);
            if (calm_left > 0)
            begin
                calm_left--;
                stall_left = 0;
            end
            else
            begin
                stall_left = $urandom_range(0, 10);
                if ($urandom_range(0, 24) == 0)
                    calm_left = 12;
            end
        end
    end

    // Long hold-off, counted here on its own: once the run is well under way,
    // refuse results for HOLD_CYCLES while the sender keeps going, so that
    // the output slot fills and the block stalls its input.
    initial
    begin
        hold_off = 1'b0;
        while (sb.sums_checked < 40)
            @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES)
        begin
            @(posedge clk);
            if (terms_if.valid && !terms_if.ready)
                sums_held++;
        end
        hold_off = 1'b0;
    end

    // Safety net: several times the slowest legal run.
    initial
    begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int        len;
        int        sel;
        int        rnd_terms;
        val_kind_e kind;
        bit        mixed;
        bit        real_only;

        // Hold every input at a known value before and during reset.
        rst_n              = 1'b0;
        terms_if.valid     = 1'b0;
        terms_if.a_re      = '0;
        terms_if.a_im      = '0;
        terms_if.b_re      = '0;
        terms_if.b_im      = '0;
        terms_if.c_re      = '0;
        terms_if.c_im      = '0;
        terms_if.last_term = 1'b0;
        sums_if.ready      = 1'b0;
        burst_tx           = 1'b0;
        stall_left         = 0;
        calm_left          = 0;
        terms_sent         = 0;
        sums_held          = 0;
        rnd_terms          = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Lone final term on cleared state: the sum is P0*c0.
        push_term(mk_term(Q_ONE, '0, Q_HALF, '0, Q_TWO, '0, 1'b1));
        // Lone final terms on both rails: P0 and the products saturate.
        push_term(mk_term(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, 1'b1));
        push_term(mk_term(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, 1'b1));

        // Two-term sum: the second-previous state is still zero, so u0 = c0.
        push_term(rand_term(VAL_SMALL, 1'b0, 1'b0, 1'b0));
        push_term(rand_term(VAL_SMALL, 1'b0, 1'b0, 1'b1));

        // Three terms with alternating rails, saturating deep in the chain.
        push_term(mk_term(W_MIN, W_MAX, W_MAX, W_MIN, W_MIN, W_MAX, 1'b0));
        push_term(mk_term(W_MAX, W_MIN, W_MIN, W_MAX, W_MAX, W_MIN, 1'b0));
        push_term(mk_term(W_NEG1, W_MAX, W_MIN, W_NEG1, W_MAX, W_MIN, 1'b1));

        // Clean sum right after saturating ones: the flag must be cleared.
        push_term(mk_term(Q_HALF, '0, Q_ONE, '0, Q_ONE, '0, 1'b0));
        push_term(mk_term(Q_HALF, '0, Q_ONE, '0, Q_ONE, '0, 1'b0));
        push_term(mk_term(Q_HALF, '0, Q_ONE, '0, Q_ONE, '0, 1'b0));
        push_term(mk_term(Q_ONE, '0, '0, '0, Q_ONE, '0, 1'b1));

        // Real data: all imaginary parts zero.
        push_term(rand_term(VAL_SMALL, 1'b0, 1'b1, 1'b0));
        push_term(rand_term(VAL_SMALL, 1'b0, 1'b1, 1'b0));
        push_term(rand_term(VAL_SMALL, 1'b0, 1'b1, 1'b1));

        // All ones everywhere: smallest negative step, truncation toward
        // minus infinity.
        push_term(mk_term(W_NEG1, W_NEG1, W_NEG1, W_NEG1, W_NEG1, W_NEG1, 1'b0));
        push_term(mk_term(W_NEG1, W_NEG1, W_NEG1, W_NEG1, W_NEG1, W_NEG1, 1'b1));

        // Random sums: mostly short, a few long ones. Most use small values so
        // the recurrence develops; the rest are full-range noise, rail values
        // or a per-field mix. Always close a sum with its final term.
        while (rnd_terms < RANDOM_TERMS)
        begin
            len       = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                    : $urandom_range(1, 8);
            sel       = $urandom_range(0, 99);
            mixed     = 1'b0;
            real_only = 1'b0;
            if (sel < 50)
                kind = VAL_SMALL;
            else if (sel < 65)
                kind = VAL_FULL;
            else if (sel < 75)
                kind = VAL_EDGE;
            else if (sel < 90)
            begin
                kind  = VAL_SMALL;
                mixed = 1'b1;
            end
            else
            begin
                kind      = VAL_SMALL;
                real_only = 1'b1;
            end
            burst_tx = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < len; i++)
            begin
                push_term(rand_term(kind, mixed, real_only, logic'(i == len - 1)));
                rnd_terms++;
            end
        end

        // Drop valid once the last term has been taken.
        @(negedge clk);
        terms_if.valid <= 1'b0;

        // Drain: wait for every expected sum, then let the block run on for a
        // while so that a stray extra result is caught.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
            $display("%0d sums never arrived", sb.pending());
        $display("Covered %0d terms in %0d checked sums, %0d of them saturating;",
                 terms_sent, sb.sums_checked, sb.sat_sums);
        $display("input was stalled %0d cycles during the long output hold-off.",
                 sums_held);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
